// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the pixel sample accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/psa_pkg.sv =====
// Package with the types, constants and helpers of the pixel sample accumulator.
package psa_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int PIXEL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(PIXEL_COUNT);
  localparam int SUM_W       = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 33;

  typedef enum logic [1:0] {
    OP_ADD_ONE = 2'd0,
    OP_ADD_CNT = 2'd1,
    OP_SPLAT   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXE,
    S_DIV
  } back_state_t;

  // One classified transaction as it waits in the queue.
  typedef struct packed {
    op_t                op;
    logic               valid;
    logic [ADDR_W-1:0]  addr;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        weight;
  } psa_item_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic      empty;
    psa_item_t head;
  } psa_queue_t;

  // Saturating 32-bit accumulate.
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Saturating 16-bit accumulate.
  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ===== hw/rtl/pixel_sample_accumulator.sv =====
// Top level of the pixel sample accumulator: front end, queue and back end.
//
//  Channel  Handshake            Payload
//  input    start, busy          in_operation, in_column, in_row, in_*_in, in_sample_weight
//  result   out_strobe (1 cycle) out_red_out, out_green_out, out_blue_out, out_empty_pixel
//  config   cfg_we               cfg_line_width
//
// After reset a clearing pass zeroes every pixel; busy stays high throughout.
// In the back end an add or splat transaction first pops the queue with the RAM read, then writes.
// A read of an empty pixel answers after the RAM read; otherwise the 33-step serial divider runs first.
// A two-entry queue lets the front accept while the back works; busy rises when it is full.
// Results are presented for one cycle and cannot be stalled by the receiver.
module pixel_sample_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_column,
  input  logic [5:0]  in_row,
  input  logic [15:0] in_red_in,
  input  logic [15:0] in_green_in,
  input  logic [15:0] in_blue_in,
  input  logic [15:0] in_sample_weight,
  output logic        out_strobe,
  output logic [15:0] out_red_out,
  output logic [15:0] out_green_out,
  output logic [15:0] out_blue_out,
  output logic        out_empty_pixel,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_line_width
);

  psa_pkg::psa_queue_t q_status;
  logic                pop;
  logic                clearing;

  // Front end with the line width register and the queue.
  psa_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_column(in_column), .in_row(in_row),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .in_sample_weight(in_sample_weight), .cfg_we(cfg_we),
    .cfg_line_width(cfg_line_width), .clearing(clearing), .pop(pop),
    .q_status(q_status)
  );

  // Back end with the pixel buffers and the divider.
  psa_back u_back (
    .clk(clk), .rst_n(rst_n), .q_status(q_status), .pop(pop), .clearing(clearing),
    .out_strobe(out_strobe), .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_empty_pixel(out_empty_pixel)
  );

endmodule

// ===== hw/rtl/psa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module psa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/psa_front.sv =====
// Front end: takes transactions, computes the pixel address and queues them.
module psa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [5:0]          in_column,
  input  logic [5:0]          in_row,
  input  logic [15:0]         in_red_in,
  input  logic [15:0]         in_green_in,
  input  logic [15:0]         in_blue_in,
  input  logic [15:0]         in_sample_weight,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_line_width,
  input  logic                clearing,
  input  logic                pop,
  output psa_pkg::psa_queue_t q_status
);

  logic [6:0]              line_width_r;
  psa_pkg::psa_item_t      queue_r [psa_pkg::QUEUE_DEPTH];
  logic                    head_r, tail_r;
  logic [1:0]              count_r;
  logic [psa_pkg::SUM_W-1:0] lin_addr;
  psa_pkg::psa_item_t      item_nxt;
  logic                    push;

  // Line width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= 7'd64;
    end else if (cfg_we) begin
      line_width_r <= cfg_line_width;
    end
  end

  // Address of the pixel and classification of the transaction.
  always_comb begin
    lin_addr = psa_pkg::SUM_W'(line_width_r) * psa_pkg::SUM_W'(in_row)
             + psa_pkg::SUM_W'(in_column);
    item_nxt.op     = psa_pkg::op_t'(in_operation);
    item_nxt.valid  = 32'(lin_addr) < psa_pkg::PIXEL_COUNT;
    item_nxt.addr   = psa_pkg::ADDR_W'(lin_addr);
    item_nxt.red    = in_red_in;
    item_nxt.green  = in_green_in;
    item_nxt.blue   = in_blue_in;
    item_nxt.weight = in_sample_weight;
  end

  assign busy = clearing || (count_r == 2'(psa_pkg::QUEUE_DEPTH));
  assign push = start && !busy;

  // Two-entry queue towards the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        tail_r <= ~tail_r;
      end
      if (pop) begin
        head_r <= ~head_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      queue_r[tail_r] <= item_nxt;
    end
  end

  assign q_status.empty = (count_r == 2'd0);
  assign q_status.head  = queue_r[head_r];

endmodule

// ===== hw/rtl/psa_back.sv =====
// Back end: clears the buffers, runs read-modify-write updates and averaging reads.
`include "assert_macros.svh"

module psa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  psa_pkg::psa_queue_t q_status,
  output logic                pop,
  output logic                clearing,
  output logic                out_strobe,
  output logic [15:0]         out_red_out,
  output logic [15:0]         out_green_out,
  output logic [15:0]         out_blue_out,
  output logic                out_empty_pixel
);

  psa_pkg::back_state_t  state_r, state_nxt;
  psa_pkg::psa_item_t    item_r, item_nxt;
  logic [psa_pkg::ADDR_W:0] clr_cnt_r, clr_cnt_nxt;
  logic [5:0]            step_r, step_nxt;
  logic [15:0]           div_r, div_nxt;
  logic [15:0]           rem_r [3];
  logic [15:0]           rem_nxt [3];
  logic [32:0]           quo_r [3];
  logic [32:0]           quo_nxt [3];
  logic                  strobe_r, strobe_nxt;
  logic [15:0]           res_r [3];
  logic [15:0]           res_nxt [3];
  logic                  empty_r, empty_nxt;

  logic [psa_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic                  col_we, spl_we, tal_we;
  logic [95:0]           col_wd, spl_wd, col_rd, spl_rd;
  logic [15:0]           tal_wd, tal_rd;
  logic [16:0]           shifted [3];
  logic [15:0]           weight;

  psa_ram #(.WIDTH(96), .DEPTH(psa_pkg::PIXEL_COUNT)) u_colour (
    .clk(clk), .we(col_we), .wr_addr(wr_addr), .wr_data(col_wd),
    .rd_addr(rd_addr), .rd_data(col_rd)
  );

  psa_ram #(.WIDTH(96), .DEPTH(psa_pkg::PIXEL_COUNT)) u_splat (
    .clk(clk), .we(spl_we), .wr_addr(wr_addr), .wr_data(spl_wd),
    .rd_addr(rd_addr), .rd_data(spl_rd)
  );

  psa_ram #(.WIDTH(16), .DEPTH(psa_pkg::PIXEL_COUNT)) u_tally (
    .clk(clk), .we(tal_we), .wr_addr(wr_addr), .wr_data(tal_wd),
    .rd_addr(rd_addr), .rd_data(tal_rd)
  );

  // State register and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= psa_pkg::S_CLEAR;
      clr_cnt_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      strobe_r  <= strobe_nxt;
    end
    item_r  <= item_nxt;
    step_r  <= step_nxt;
    div_r   <= div_nxt;
    empty_r <= empty_nxt;
    for (int i = 0; i < 3; i++) begin
      rem_r[i] <= rem_nxt[i];
      quo_r[i] <= quo_nxt[i];
      res_r[i] <= res_nxt[i];
    end
  end

  // Next state, memory control and one restoring division step per lane.
  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    clr_cnt_nxt = clr_cnt_r;
    step_nxt    = step_r;
    div_nxt     = div_r;
    strobe_nxt  = 1'b0;
    empty_nxt   = empty_r;
    pop         = 1'b0;
    rd_addr     = q_status.head.addr;
    wr_addr     = item_r.addr;
    col_we      = 1'b0;
    spl_we      = 1'b0;
    tal_we      = 1'b0;
    weight      = (item_r.op == psa_pkg::OP_ADD_ONE) ? 16'd1 : item_r.weight;
    col_wd = {psa_pkg::sat_add32(col_rd[95:64], item_r.red),
              psa_pkg::sat_add32(col_rd[63:32], item_r.green),
              psa_pkg::sat_add32(col_rd[31:0], item_r.blue)};
    spl_wd = {psa_pkg::sat_add32(spl_rd[95:64], item_r.red),
              psa_pkg::sat_add32(spl_rd[63:32], item_r.green),
              psa_pkg::sat_add32(spl_rd[31:0], item_r.blue)};
    tal_wd = psa_pkg::sat_add16(tal_rd, weight);
    for (int i = 0; i < 3; i++) begin
      rem_nxt[i] = rem_r[i];
      quo_nxt[i] = quo_r[i];
      res_nxt[i] = res_r[i];
      shifted[i] = {rem_r[i], quo_r[i][32]};
    end

    case (state_r)
      psa_pkg::S_CLEAR: begin
        wr_addr     = clr_cnt_r[psa_pkg::ADDR_W-1:0];
        col_we      = 1'b1;
        spl_we      = 1'b1;
        tal_we      = 1'b1;
        col_wd      = '0;
        spl_wd      = '0;
        tal_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + (psa_pkg::ADDR_W+1)'(1);
        if (clr_cnt_r == (psa_pkg::ADDR_W+1)'(psa_pkg::PIXEL_COUNT - 1)) begin
          state_nxt = psa_pkg::S_IDLE;
        end
      end
      psa_pkg::S_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          item_nxt  = q_status.head;
          state_nxt = psa_pkg::S_EXE;
        end
      end
      psa_pkg::S_EXE: begin
        state_nxt = psa_pkg::S_IDLE;
        case (item_r.op)
          psa_pkg::OP_READ: begin
            if (!item_r.valid || tal_rd == 16'd0) begin
              strobe_nxt = 1'b1;
              empty_nxt  = 1'b1;
              for (int i = 0; i < 3; i++) begin
                res_nxt[i] = 16'd0;
              end
            end else begin
              empty_nxt = 1'b0;
              div_nxt   = tal_rd;
              step_nxt  = 6'd0;
              for (int i = 0; i < 3; i++) begin
                rem_nxt[i] = 16'd0;
                quo_nxt[i] = {1'b0, col_rd[i*32 +: 32]} + {1'b0, spl_rd[i*32 +: 32]};
              end
              state_nxt = psa_pkg::S_DIV;
            end
          end
          psa_pkg::OP_SPLAT: begin
            spl_we = item_r.valid;
          end
          default: begin
            col_we = item_r.valid;
            tal_we = item_r.valid;
          end
        endcase
      end
      psa_pkg::S_DIV: begin
        step_nxt = step_r + 6'd1;
        for (int i = 0; i < 3; i++) begin
          if (shifted[i] >= {1'b0, div_r}) begin
            rem_nxt[i] = 16'(shifted[i] - {1'b0, div_r});
            quo_nxt[i] = {quo_r[i][31:0], 1'b1};
          end else begin
            rem_nxt[i] = shifted[i][15:0];
            quo_nxt[i] = {quo_r[i][31:0], 1'b0};
          end
          res_nxt[i] = (|quo_nxt[i][32:16]) ? 16'hFFFF : quo_nxt[i][15:0];
        end
        if (step_r == 6'(psa_pkg::DIV_STEPS - 1)) begin
          strobe_nxt = 1'b1;
          state_nxt  = psa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = psa_pkg::S_IDLE;
      end
    endcase
  end

  assign clearing        = (state_r == psa_pkg::S_CLEAR);
  assign out_strobe      = strobe_r;
  assign out_red_out     = res_r[2];
  assign out_green_out   = res_r[1];
  assign out_blue_out    = res_r[0];
  assign out_empty_pixel = empty_r;

  // The queue is only taken from when it holds a transaction.
  `ASSERT_SAME(a_pop_nonempty, clk, rst_n, pop, !q_status.empty)
  // The last division step is followed by a result.
  `ASSERT_NEXT(a_div_done, clk, rst_n,
    (state_r == psa_pkg::S_DIV) && (step_r == 6'(psa_pkg::DIV_STEPS - 1)), out_strobe)
  // No result leaves while the clearing pass is still running.
  `ASSERT_SAME(a_no_result_clear, clk, rst_n, clearing, !out_strobe)

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the pixel sample accumulator.
`timescale 1ns / 1ps

module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [5:0]  in_column = '0;
  logic [5:0]  in_row = '0;
  logic [15:0] in_red_in = '0;
  logic [15:0] in_green_in = '0;
  logic [15:0] in_blue_in = '0;
  logic [15:0] in_sample_weight = '0;
  logic        out_strobe;
  logic [15:0] out_red_out;
  logic [15:0] out_green_out;
  logic [15:0] out_blue_out;
  logic        out_empty_pixel;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_line_width = '0;

  // One expected pixel average.
  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        empty;
  } pixel_avg_t;

  // Own copy of the film state.
  logic [31:0] film_colour_r [psa_pkg::PIXEL_COUNT];
  logic [31:0] film_colour_g [psa_pkg::PIXEL_COUNT];
  logic [31:0] film_colour_b [psa_pkg::PIXEL_COUNT];
  logic [31:0] film_splat_r [psa_pkg::PIXEL_COUNT];
  logic [31:0] film_splat_g [psa_pkg::PIXEL_COUNT];
  logic [31:0] film_splat_b [psa_pkg::PIXEL_COUNT];
  logic [15:0] film_tally [psa_pkg::PIXEL_COUNT];
  logic [6:0]  film_line_width;

  pixel_avg_t pending_averages [$];
  int         mismatch_count = 0;
  bit         idling_on = 1'b1;

  always #1 clk = ~clk;

  pixel_sample_accumulator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_column(in_column), .in_row(in_row),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .in_sample_weight(in_sample_weight),
    .out_strobe(out_strobe), .out_red_out(out_red_out),
    .out_green_out(out_green_out), .out_blue_out(out_blue_out),
    .out_empty_pixel(out_empty_pixel),
    .cfg_we(cfg_we), .cfg_line_width(cfg_line_width)
  );

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [15:0] channel_average(input logic [31:0] c, input logic [31:0] s,
                                                  input logic [15:0] t);
    logic [32:0] q;
    q = ({1'b0, c} + {1'b0, s}) / 33'(t);
    return (q > 33'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  // Applies one transaction to the film copy; a read queues its expected average.
  task automatic predict_film(input psa_pkg::op_t op, input logic [5:0] col,
                              input logic [5:0] row,
                              input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic [15:0] w);
    int unsigned addr;
    pixel_avg_t  avg;
    logic [16:0] t;
    addr = 32'(col) + 32'(film_line_width) * 32'(row);
    if (op == psa_pkg::OP_READ) begin
      if (addr >= psa_pkg::PIXEL_COUNT || film_tally[addr] == 0) begin
        avg = '{16'd0, 16'd0, 16'd0, 1'b1};
      end else begin
        avg.red   = channel_average(film_colour_r[addr], film_splat_r[addr], film_tally[addr]);
        avg.green = channel_average(film_colour_g[addr], film_splat_g[addr], film_tally[addr]);
        avg.blue  = channel_average(film_colour_b[addr], film_splat_b[addr], film_tally[addr]);
        avg.empty = 1'b0;
      end
      pending_averages.push_back(avg);
    end else if (addr < psa_pkg::PIXEL_COUNT) begin
      if (op == psa_pkg::OP_SPLAT) begin
        film_splat_r[addr] = add_sat32(film_splat_r[addr], r);
        film_splat_g[addr] = add_sat32(film_splat_g[addr], g);
        film_splat_b[addr] = add_sat32(film_splat_b[addr], b);
      end else begin
        film_colour_r[addr] = add_sat32(film_colour_r[addr], r);
        film_colour_g[addr] = add_sat32(film_colour_g[addr], g);
        film_colour_b[addr] = add_sat32(film_colour_b[addr], b);
        t = {1'b0, film_tally[addr]} + 17'((op == psa_pkg::OP_ADD_ONE) ? 16'd1 : w);
        film_tally[addr] = t[16] ? 16'hFFFF : t[15:0];
      end
    end
  endtask

  // Sends one transaction and waits for the edge that takes it; may then idle with start low.
  task automatic send_pixel_op(input psa_pkg::op_t op, input logic [5:0] col,
                               input logic [5:0] row,
                               input logic [15:0] r, input logic [15:0] g,
                               input logic [15:0] b, input logic [15:0] w);
    start <= 1'b1;
    in_operation <= op;
    in_column <= col;
    in_row <= row;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    in_sample_weight <= w;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_film(op, col, row, r, g, b, w);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Waits until every read has answered and the back end has finished any adds.
  task automatic drain_film;
    start <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_line_width(input logic [6:0] value);
    drain_film();
    cfg_we <= 1'b1;
    cfg_line_width <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    film_line_width = value;
  endtask

  // Each result is compared with the oldest expected average.
  always @(negedge clk) begin
    pixel_avg_t want;
    if (rst_n && out_strobe) begin
      if (pending_averages.size() == 0) begin
        report_mismatch("result with no read outstanding");
      end else begin
        want = pending_averages.pop_front();
        if (out_red_out !== want.red)
          report_mismatch($sformatf("red %h, expected %h", out_red_out, want.red));
        if (out_green_out !== want.green)
          report_mismatch($sformatf("green %h, expected %h", out_green_out, want.green));
        if (out_blue_out !== want.blue)
          report_mismatch($sformatf("blue %h, expected %h", out_blue_out, want.blue));
        if (out_empty_pixel !== want.empty)
          report_mismatch($sformatf("empty %b, expected %b", out_empty_pixel, want.empty));
      end
    end
  end

  // Extremes, every operation, empty pixels, zero and full weights.
  task automatic test_directed_ops;
    send_pixel_op(psa_pkg::OP_READ, 6'd0, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel_op(psa_pkg::OP_ADD_ONE, 6'd0, 6'd0, 16'hFFFF, 16'h0000, 16'h1000, 16'h0000);
    send_pixel_op(psa_pkg::OP_READ, 6'd0, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_pixel_op(psa_pkg::OP_ADD_CNT, 6'd63, 6'd63, 16'h1234, 16'hFFFF, 16'h0001, 16'd0);
    send_pixel_op(psa_pkg::OP_READ, 6'd63, 6'd63, 16'h0, 16'h0, 16'h0, 16'h0);
    send_pixel_op(psa_pkg::OP_ADD_CNT, 6'd63, 6'd63, 16'h8000, 16'h8000, 16'h8000, 16'd3);
    send_pixel_op(psa_pkg::OP_SPLAT, 6'd63, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel_op(psa_pkg::OP_READ, 6'd63, 6'd63, 16'h0, 16'h0, 16'h0, 16'h0);
    send_pixel_op(psa_pkg::OP_SPLAT, 6'd1, 6'd2, 16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_pixel_op(psa_pkg::OP_READ, 6'd1, 6'd2, 16'h0, 16'h0, 16'h0, 16'h0);
    send_pixel_op(psa_pkg::OP_ADD_CNT, 6'd1, 6'd2, 16'h0100, 16'h0200, 16'h0300, 16'hFFFF);
    send_pixel_op(psa_pkg::OP_ADD_CNT, 6'd1, 6'd2, 16'h0100, 16'h0200, 16'h0300, 16'hFFFF);
    send_pixel_op(psa_pkg::OP_READ, 6'd1, 6'd2, 16'h0, 16'h0, 16'h0, 16'h0);
  endtask

  // Heavy weights drive the tally into saturation; a single-sample pixel with
  // large sums drives the average into saturation.
  task automatic test_saturation;
    idling_on = 1'b0;
    for (int i = 0; i < 3; i++)
      send_pixel_op(psa_pkg::OP_ADD_CNT, 6'd5, 6'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel_op(psa_pkg::OP_SPLAT, 6'd5, 6'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0);
    send_pixel_op(psa_pkg::OP_READ, 6'd5, 6'd5, 16'h0, 16'h0, 16'h0, 16'h0);
    send_pixel_op(psa_pkg::OP_ADD_ONE, 6'd6, 6'd5, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0);
    for (int i = 0; i < 8; i++)
      send_pixel_op(psa_pkg::OP_ADD_CNT, 6'd6, 6'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    send_pixel_op(psa_pkg::OP_SPLAT, 6'd6, 6'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0);
    send_pixel_op(psa_pkg::OP_READ, 6'd6, 6'd5, 16'h0, 16'h0, 16'h0, 16'h0);
    idling_on = 1'b1;
  endtask

  // Narrow, zero and over-wide lines: columns spill into later rows or out of range.
  task automatic test_line_width_cases;
    write_line_width(7'd1);
    send_pixel_op(psa_pkg::OP_ADD_ONE, 6'd63, 6'd0, 16'h1000, 16'h2000, 16'h3000, 16'h0);
    send_pixel_op(psa_pkg::OP_READ, 6'd0, 6'd63, 16'h0, 16'h0, 16'h0, 16'h0);
    write_line_width(7'd0);
    send_pixel_op(psa_pkg::OP_ADD_ONE, 6'd7, 6'd40, 16'h0400, 16'h0400, 16'h0400, 16'h0);
    send_pixel_op(psa_pkg::OP_READ, 6'd7, 6'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    write_line_width(7'd127);
    send_pixel_op(psa_pkg::OP_ADD_ONE, 6'd63, 6'd63, 16'h1111, 16'h1111, 16'h1111, 16'h0);
    send_pixel_op(psa_pkg::OP_READ, 6'd63, 6'd63, 16'h0, 16'h0, 16'h0, 16'h0);
    send_pixel_op(psa_pkg::OP_READ, 6'd14, 6'd32, 16'h0, 16'h0, 16'h0, 16'h0);
  endtask

  // Random transactions over a handful of hot pixels, with occasional wide addresses.
  task automatic test_random_phase(input logic [6:0] width, input int count, input bit idle);
    psa_pkg::op_t op;
    logic [5:0]   col, row;
    logic [15:0]  w;
    write_line_width(width);
    idling_on = idle;
    for (int i = 0; i < count; i++) begin
      op = psa_pkg::op_t'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) begin
        col = 6'($urandom);
        row = 6'($urandom);
      end else begin
        col = 6'($urandom_range(0, 3));
        row = 6'($urandom_range(0, 2));
      end
      w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      send_pixel_op(op, col, row, 16'($urandom), 16'($urandom), 16'($urandom), w);
    end
    idling_on = 1'b1;
  endtask

  initial begin
    film_line_width = 7'd64;
    for (int i = 0; i < psa_pkg::PIXEL_COUNT; i++) begin
      film_colour_r[i] = '0; film_colour_g[i] = '0; film_colour_b[i] = '0;
      film_splat_r[i] = '0;  film_splat_g[i] = '0;  film_splat_b[i] = '0;
      film_tally[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The clearing pass holds busy high; wait for it to finish.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    write_line_width(7'd64);

    test_directed_ops();
    test_saturation();
    test_line_width_cases();
    test_random_phase(7'd64, 400, 1'b1);
    test_random_phase(7'd1, 300, 1'b1);
    test_random_phase(7'd127, 300, 1'b1);
    test_random_phase(7'd0, 250, 1'b1);
    test_random_phase(7'($urandom_range(2, 126)), 250, 1'b1);
    test_random_phase(7'd64, 250, 1'b0);

    drain_film();
    if (pending_averages.size() != 0)
      report_mismatch("reads left without a result");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/psa_pkg.sv
hw/rtl/psa_ram.sv
hw/rtl/psa_front.sv
hw/rtl/psa_back.sv
hw/rtl/pixel_sample_accumulator.sv
bench/testbench.sv
